[hdl/elevation_grid_min_max_macros.svh]
// ----------------------------------------------------------------------------
// elevation grid assertion macros
// concurrent assertion forms for the elevation grid checker
// ----------------------------------------------------------------------------
`ifndef ELEVATION_GRID_MIN_MAX_MACROS_SVH
`define ELEVATION_GRID_MIN_MAX_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define EGM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// implication with a fixed delay in cycles
`define EGM_ASSERT_DLY(label, clk, rst_n, ante, n, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

[hdl/egm_pkg.sv]
// ----------------------------------------------------------------------------
// egm_pkg
// types, codes and constants shared by the elevation grid blocks
// ----------------------------------------------------------------------------
`default_nettype none

package egm_pkg;

	// grid size defaults
	localparam int EGM_MAX_ROWS = 256;
	localparam int EGM_MAX_COLS = 256;

	// datapath widths
	localparam int COORD_W    = 32;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int INV_W      = 16;
	localparam int PROD_W     = DIFF_W + INV_W;
	localparam int FRAC_SHIFT = 24;
	localparam int DIM_W      = 9;
	localparam int IDX_W      = 2 * DIM_W;
	localparam int CELL_W     = 16;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// accept edge to result strobe, in cycles
	localparam int EGM_LATENCY = 6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_RES  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 3'd4;

	// register reset values
	localparam logic [INV_W-1:0] CFG_INV_RES_RST = 16'd2560;
	localparam logic [DIM_W-1:0] CFG_DIM_RST     = 9'd256;

	// operations
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// result status
	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

	typedef struct packed {
		logic                      op;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic [CELL_W-1:0]         read_cell;
	} egm_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic [CELL_W-1:0]         cell_index;
		logic                      cell_valid;
		logic signed [COORD_W-1:0] min_height;
		logic signed [COORD_W-1:0] max_height;
		logic [COORD_W-1:0]        clearance;
	} egm_result_t;

	// live configuration, rows and cols already saturated
	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic [INV_W-1:0]          inv_res;
		logic [DIM_W-1:0]          rows;
		logic [DIM_W-1:0]          cols;
		logic [IDX_W-1:0]          cells;
	} egm_cfg_t;

	// item after address resolution
	typedef struct packed {
		logic                      is_read;
		logic [STATUS_W-1:0]       status;
		logic [IDX_W-1:0]          idx;
		logic signed [COORD_W-1:0] z;
	} egm_stage_t;

	// one grid cell as stored
	typedef struct packed {
		logic                      valid;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] max_z;
	} egm_word_t;

	// cell write-back
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		egm_word_t        word;
	} egm_wr_t;

endpackage

`default_nettype wire

[hdl/elevation_grid_min_max.sv]
// ----------------------------------------------------------------------------
// elevation_grid_min_max: min/max height grid; done is registered after the s1-s4 address and s5 update stages
// one beat per clock while not busy; the cell memory read-modify-write with one-deep forwarding sets it
// reset: busy while the cell memory is swept clear
// results are strobed on done for one cycle and cannot be held off
// ----------------------------------------------------------------------------
`default_nettype none

module elevation_grid_min_max
	import egm_pkg::*;
#(
	parameter int MAX_ROWS = EGM_MAX_ROWS,
	parameter int MAX_COLS = EGM_MAX_COLS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire egm_item_t             item,
	output logic                       done,
	output egm_result_t                result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	egm_cfg_t   cfg;
	logic       accept;
	logic       s4_valid;
	egm_stage_t s4;
	egm_word_t  rd_data;
	egm_wr_t    wr;
	logic       clearing;

	assign busy   = clearing;
	assign accept = start && !busy;

	// configuration registers
	egm_cfg #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// address pipeline
	egm_addr u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg      (cfg),
		.s4_valid (s4_valid),
		.s4       (s4)
	);

	// cell memory
	egm_mem #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (s4.idx),
		.wr       (wr),
		.rd_data  (rd_data),
		.clearing (clearing)
	);

	// update and result
	egm_update u_update (
		.clk      (clk),
		.arst_n   (arst_n),
		.s4_valid (s4_valid),
		.s4       (s4),
		.rd_data  (rd_data),
		.wr       (wr),
		.done     (done),
		.result   (result)
	);

endmodule

`default_nettype wire

[hdl/egm_cfg.sv]
// ----------------------------------------------------------------------------
// egm_cfg
// configuration registers with saturated grid size and cell count
// ----------------------------------------------------------------------------
`default_nettype none

module egm_cfg
	import egm_pkg::*;
#(
	parameter int MAX_ROWS = EGM_MAX_ROWS,
	parameter int MAX_COLS = EGM_MAX_COLS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output egm_cfg_t                   cfg
);

	// caps that fit the row and column registers
	localparam int DIM_MAX = (1 << DIM_W) - 1;
	localparam int ROW_CAP = (MAX_ROWS < DIM_MAX) ? MAX_ROWS : DIM_MAX;
	localparam int COL_CAP = (MAX_COLS < DIM_MAX) ? MAX_COLS : DIM_MAX;

	logic signed [COORD_W-1:0] origin_x_q;
	logic signed [COORD_W-1:0] origin_y_q;
	logic [INV_W-1:0]          inv_res_q;
	logic [DIM_W-1:0]          rows_q;
	logic [DIM_W-1:0]          cols_q;
	logic [IDX_W-1:0]          cells_q;
	logic [DIM_W-1:0]          eff_rows;
	logic [DIM_W-1:0]          eff_cols;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			inv_res_q  <= CFG_INV_RES_RST;
			rows_q     <= CFG_DIM_RST;
			cols_q     <= CFG_DIM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIGIN_X: origin_x_q <= cfg_wdata[COORD_W-1:0];
				CFG_ORIGIN_Y: origin_y_q <= cfg_wdata[COORD_W-1:0];
				CFG_INV_RES:  inv_res_q  <= cfg_wdata[INV_W-1:0];
				CFG_ROWS:     rows_q     <= cfg_wdata[DIM_W-1:0];
				CFG_COLS:     cols_q     <= cfg_wdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// saturate to the grid the memory holds
	assign eff_rows = (rows_q > DIM_W'(ROW_CAP)) ? DIM_W'(ROW_CAP) : rows_q;
	assign eff_cols = (cols_q > DIM_W'(COL_CAP)) ? DIM_W'(COL_CAP) : cols_q;

	// cell count for the read range check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q <= '0;
		end else begin
			cells_q <= IDX_W'(eff_rows) * IDX_W'(eff_cols);
		end
	end

	assign cfg.origin_x = origin_x_q;
	assign cfg.origin_y = origin_y_q;
	assign cfg.inv_res  = inv_res_q;
	assign cfg.rows     = eff_rows;
	assign cfg.cols     = eff_cols;
	assign cfg.cells    = cells_q;

endmodule

`default_nettype wire

[hdl/egm_addr.sv]
// ----------------------------------------------------------------------------
// egm_addr
// four-stage pipeline from point coordinates or read index to cell address
// ----------------------------------------------------------------------------
`default_nettype none

module egm_addr
	import egm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      accept,
	input  wire egm_item_t item,
	input  wire egm_cfg_t  cfg,
	output logic           s4_valid,
	output egm_stage_t     s4
);

	localparam int CNUM_W = PROD_W - 1 - FRAC_SHIFT;

	logic                      v_s1, v_s2, v_s3, v_s4;
	logic                      op_s1, op_s2, op_s3;
	logic signed [DIFF_W-1:0]  dx_s1, dy_s1;
	logic signed [COORD_W-1:0] z_s1, z_s2, z_s3;
	logic [CELL_W-1:0]         rc_s1, rc_s2, rc_s3;
	logic signed [PROD_W-1:0]  px_s2, py_s2;
	logic signed [INV_W:0]     inv_s;
	logic                      x_in, y_in;
	logic [DIM_W-1:0]          col_s3, row_s3;
	logic                      outside_s3;
	logic                      rd_range_s3;
	egm_stage_t                stage_n;
	egm_stage_t                stage_s4;

	// beat valid through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// s1: offsets from the grid origin
	always_ff @(posedge clk) begin
		op_s1 <= item.op;
		dx_s1 <= DIFF_W'(item.point_x) - DIFF_W'(cfg.origin_x);
		dy_s1 <= DIFF_W'(item.point_y) - DIFF_W'(cfg.origin_y);
		z_s1  <= item.point_z;
		rc_s1 <= item.read_cell;
	end

	// s2: scale by cells per metre, Q24.24 result
	assign inv_s = {1'b0, cfg.inv_res};

	always_ff @(posedge clk) begin
		op_s2 <= op_s1;
		px_s2 <= dx_s1 * inv_s;
		py_s2 <= dy_s1 * inv_s;
		z_s2  <= z_s1;
		rc_s2 <= rc_s1;
	end

	// s3: floor and bounds check
	assign x_in = !px_s2[PROD_W-1] &&
		(px_s2[PROD_W-2:FRAC_SHIFT] < CNUM_W'(cfg.cols));
	assign y_in = !py_s2[PROD_W-1] &&
		(py_s2[PROD_W-2:FRAC_SHIFT] < CNUM_W'(cfg.rows));

	always_ff @(posedge clk) begin
		op_s3       <= op_s2;
		col_s3      <= px_s2[FRAC_SHIFT +: DIM_W];
		row_s3      <= py_s2[FRAC_SHIFT +: DIM_W];
		outside_s3  <= !(x_in && y_in);
		rd_range_s3 <= IDX_W'(rc_s2) >= cfg.cells;
		z_s3        <= z_s2;
		rc_s3       <= rc_s2;
	end

	// s4: row-major index and status
	always_comb begin
		stage_n.is_read = (op_s3 == OP_READ);
		stage_n.z       = z_s3;
		if (op_s3 == OP_READ) begin
			stage_n.status = rd_range_s3 ? STATUS_RANGE : STATUS_OK;
			stage_n.idx    = IDX_W'(rc_s3);
		end else if (outside_s3) begin
			stage_n.status = STATUS_OUTSIDE;
			stage_n.idx    = '0;
		end else begin
			stage_n.status = STATUS_OK;
			stage_n.idx    = IDX_W'(row_s3) * IDX_W'(cfg.cols) + IDX_W'(col_s3);
		end
	end

	always_ff @(posedge clk) begin
		stage_s4 <= stage_n;
	end

	assign s4_valid = v_s4;
	assign s4       = stage_s4;

endmodule

`default_nettype wire

[hdl/egm_mem.sv]
// ----------------------------------------------------------------------------
// egm_mem
// cell memory, one read and one write port, with the post-reset clear sweep
// ----------------------------------------------------------------------------
`default_nettype none

module egm_mem
	import egm_pkg::*;
#(
	parameter int MAX_ROWS = EGM_MAX_ROWS,
	parameter int MAX_COLS = EGM_MAX_COLS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] rd_idx,
	input  wire egm_wr_t          wr,
	output egm_word_t             rd_data,
	output logic                  clearing
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	egm_word_t         mem [DEPTH];
	egm_word_t         rd_data_q;
	logic              clear_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// clear sweep, one entry per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clear_q <= 1'b0;
			end
		end
	end

	// storage, registered read
	always_ff @(posedge clk) begin
		if (clear_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr.en) begin
			mem[ADDR_W'(wr.idx)] <= wr.word;
		end
		rd_data_q <= mem[ADDR_W'(rd_idx)];
	end

	assign rd_data  = rd_data_q;
	assign clearing = clear_q;

endmodule

`default_nettype wire

[hdl/egm_update.sv]
// ----------------------------------------------------------------------------
// egm_update
// cell read-modify-write with write forwarding, and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module egm_update
	import egm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s4_valid,
	input  wire egm_stage_t s4,
	input  wire egm_word_t  rd_data,
	output egm_wr_t         wr,
	output logic            done,
	output egm_result_t     result
);

	logic        v_s5;
	egm_stage_t  st_s5;
	logic        lw_valid_q;
	logic [IDX_W-1:0] lw_idx_q;
	egm_word_t   lw_word_q;
	logic        done_q;
	egm_result_t result_q;
	egm_word_t   old_word;
	egm_word_t   upd_word;
	egm_word_t   show_word;
	egm_wr_t     wr_n;
	egm_result_t res_n;

	// s5 lines up with the memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5       <= 1'b0;
			lw_valid_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			v_s5       <= s4_valid;
			lw_valid_q <= wr_n.en;
			done_q     <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		st_s5     <= s4;
		lw_idx_q  <= wr_n.idx;
		lw_word_q <= wr_n.word;
		result_q  <= res_n;
	end

	// previous beat wrote this cell at the edge of our read
	assign old_word = (lw_valid_q && lw_idx_q == st_s5.idx) ? lw_word_q : rd_data;

	// widen min and max to take the new height
	always_comb begin
		upd_word.valid = 1'b1;
		if (!old_word.valid) begin
			upd_word.min_z = st_s5.z;
			upd_word.max_z = st_s5.z;
		end else begin
			upd_word.min_z = (st_s5.z < old_word.min_z) ? st_s5.z : old_word.min_z;
			upd_word.max_z = (st_s5.z > old_word.max_z) ? st_s5.z : old_word.max_z;
		end
	end

	assign show_word = st_s5.is_read ? old_word : upd_word;

	// result fields and write-back
	always_comb begin
		res_n            = '0;
		res_n.status     = st_s5.status;
		res_n.cell_index = st_s5.idx[CELL_W-1:0];
		wr_n             = '0;
		wr_n.idx         = st_s5.idx;
		if (v_s5 && st_s5.status == STATUS_OK) begin
			res_n.cell_valid = show_word.valid;
			if (show_word.valid) begin
				res_n.min_height = show_word.min_z;
				res_n.max_height = show_word.max_z;
				res_n.clearance  = show_word.max_z - show_word.min_z;
			end
			wr_n.en   = 1'b1;
			wr_n.word = show_word;
			// a read hands the cell back empty
			if (st_s5.is_read) begin
				wr_n.word.valid = 1'b0;
			end
		end
	end

	assign wr     = wr_n;
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

[hdl/egm_checker.sv]
// ----------------------------------------------------------------------------
// egm_checker
// port-level checks on the elevation grid, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "elevation_grid_min_max_macros.svh"

module egm_checker
	import egm_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire egm_result_t result
);

	// every accepted beat gives one result at fixed latency
	`EGM_ASSERT_DLY(a_result_follows, clk, arst_n, start && !busy, EGM_LATENCY, done, "accepted beat gave no result")

	// no result without an accepted beat
	`EGM_ASSERT_IMP(a_no_phantom, clk, arst_n, done, $past(start && !busy, EGM_LATENCY), "result without accepted beat")

	// nothing comes out during the clear sweep
	`EGM_ASSERT_IMP(a_quiet_clear, clk, arst_n, busy, !done, "result during clear sweep")

	// rejected beats carry an empty cell
	`EGM_ASSERT_IMP(a_reject_empty, clk, arst_n, done && (result.status == STATUS_OUTSIDE || result.status == STATUS_RANGE), !result.cell_valid && result.min_height == '0 && result.max_height == '0 && result.clearance == '0, "rejected beat with cell data")

	// clearance matches the reported heights
	`EGM_ASSERT_IMP(a_clearance, clk, arst_n, done && result.cell_valid, result.clearance == COORD_W'(result.max_height - result.min_height) && result.max_height >= result.min_height, "clearance mismatch")

endmodule

bind elevation_grid_min_max egm_checker u_egm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire

[test/elevation_grid_min_max_tb.sv]
// ----------------------------------------------------------------------------
// elevation_grid_min_max_tb
// drives point inserts and cell reads into the min/max height grid, keeps a
// software copy of the grid and its registers, and checks every result beat
// field by field; covers register extremes, empty grids and saturated sizes
// ----------------------------------------------------------------------------
module elevation_grid_min_max_tb
	import egm_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 5;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int REPORT_LIMIT = 10;
	localparam int CELL_COUNT   = EGM_MAX_ROWS * EGM_MAX_COLS;
	localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh80000000;
	localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFFFFFF;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	egm_item_t             item      = '0;
	logic                  done;
	egm_result_t           result;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// mirror of the grid registers
	logic signed [COORD_W-1:0] grid_ox    = '0;
	logic signed [COORD_W-1:0] grid_oy    = '0;
	logic [INV_W-1:0]          grid_inv   = CFG_INV_RES_RST;
	logic [DIM_W-1:0]          grid_nrows = CFG_DIM_RST;
	logic [DIM_W-1:0]          grid_ncols = CFG_DIM_RST;

	// mirror of the cell memory
	bit                        cell_occupied [CELL_COUNT];
	logic signed [COORD_W-1:0] cell_low      [CELL_COUNT];
	logic signed [COORD_W-1:0] cell_high     [CELL_COUNT];

	egm_result_t cell_reports_due [$];
	int          report_errors = 0;
	int          cycle_count   = 0;
	int          idle_pct      = 0;

	elevation_grid_min_max dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #CLK_HALF clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// sizes in use, saturated to the instance maximum
	function automatic int live_rows();
		return (grid_nrows > EGM_MAX_ROWS) ? EGM_MAX_ROWS : int'(grid_nrows);
	endfunction

	function automatic int live_cols();
		return (grid_ncols > EGM_MAX_COLS) ? EGM_MAX_COLS : int'(grid_ncols);
	endfunction

	// floor((pos - org) * inv) in cells, -1 when off the grid
	function automatic int axis_cell(input logic signed [COORD_W-1:0] pos,
			input logic signed [COORD_W-1:0] org, input int limit);
		longint prod;
		prod = (longint'(pos) - longint'(org)) * longint'(grid_inv);
		if (prod < 0 || (prod >>> FRAC_SHIFT) >= limit)
			return -1;
		return int'(prod >>> FRAC_SHIFT);
	endfunction

	// applies one beat to the grid copy and returns the cell report it causes
	function automatic egm_result_t apply_to_grid(input egm_item_t beat);
		egm_result_t rep;
		int          nr;
		int          nc;
		int          col;
		int          row;
		int          idx;
		rep = '0;
		nr  = live_rows();
		nc  = live_cols();
		if (beat.op == OP_INSERT) begin
			col = axis_cell(beat.point_x, grid_ox, nc);
			row = axis_cell(beat.point_y, grid_oy, nr);
			if (col < 0 || row < 0) begin
				rep.status = STATUS_OUTSIDE;
				return rep;
			end
			idx = row * nc + col;
			if (!cell_occupied[idx]) begin
				cell_occupied[idx] = 1'b1;
				cell_low[idx]      = beat.point_z;
				cell_high[idx]     = beat.point_z;
			end else begin
				if (beat.point_z < cell_low[idx])
					cell_low[idx] = beat.point_z;
				if (beat.point_z > cell_high[idx])
					cell_high[idx] = beat.point_z;
			end
		end else begin
			idx = int'(beat.read_cell);
			rep.cell_index = beat.read_cell;
			if (idx >= nr * nc) begin
				rep.status = STATUS_RANGE;
				return rep;
			end
		end
		rep.status     = STATUS_OK;
		rep.cell_index = idx[CELL_W-1:0];
		rep.cell_valid = cell_occupied[idx];
		if (cell_occupied[idx]) begin
			rep.min_height = cell_low[idx];
			rep.max_height = cell_high[idx];
			rep.clearance  = cell_high[idx] - cell_low[idx];
		end
		// a read empties the cell
		if (beat.op == OP_READ)
			cell_occupied[idx] = 1'b0;
		return rep;
	endfunction

	function automatic egm_item_t point_beat(input logic signed [COORD_W-1:0] x, y, z);
		egm_item_t b;
		b.op        = OP_INSERT;
		b.point_x   = x;
		b.point_y   = y;
		b.point_z   = z;
		b.read_cell = CELL_W'($urandom);
		return b;
	endfunction

	function automatic egm_item_t read_beat(input logic [CELL_W-1:0] cidx);
		egm_item_t b;
		b.op        = OP_READ;
		b.point_x   = $urandom;
		b.point_y   = $urandom;
		b.point_z   = $urandom;
		b.read_cell = cidx;
		return b;
	endfunction

	// coordinate aimed mostly at a cell inside the grid along one axis
	function automatic logic signed [COORD_W-1:0] aim_axis(
			input logic signed [COORD_W-1:0] org, input int limit);
		longint d;
		int     c;
		if (limit == 0 || grid_inv == 0 || $urandom_range(99) < 8)
			return $urandom;
		if ($urandom_range(99) < 8) begin
			d = -longint'($urandom_range(1, 5000));
		end else begin
			c = $urandom_range(0, limit - 1);
			d = ((longint'(c) << FRAC_SHIFT) + longint'($urandom_range(0, 32'hFFFFFF)))
				/ longint'(grid_inv);
		end
		return COORD_W'(longint'(org) + d);
	endfunction

	function automatic logic signed [COORD_W-1:0] pick_height();
		int sel;
		sel = $urandom_range(99);
		if (sel < 50)
			return $urandom;
		if (sel < 85)
			return COORD_W'($urandom_range(0, 4000)) - 32'sd2000;
		case ($urandom_range(3))
			0:       return Q_MIN;
			1:       return Q_MAX;
			2:       return '0;
			default: return -32'sd1;
		endcase
	endfunction

	// mostly well-formed inserts and reads, some pure noise
	function automatic egm_item_t traffic_beat();
		egm_item_t b;
		int        cells;
		cells = live_rows() * live_cols();
		if ($urandom_range(99) < 10) begin
			b.op        = 1'($urandom);
			b.point_x   = $urandom;
			b.point_y   = $urandom;
			b.point_z   = $urandom;
			b.read_cell = CELL_W'($urandom);
			return b;
		end
		if ($urandom_range(99) < 70)
			return point_beat(aim_axis(grid_ox, live_cols()), aim_axis(grid_oy, live_rows()),
				pick_height());
		if (cells > 0 && $urandom_range(99) < 80)
			return read_beat(CELL_W'($urandom_range(0, cells - 1)));
		return read_beat(CELL_W'($urandom));
	endfunction

	// one beat in, with random idle cycles ahead of it
	task automatic send_item(input egm_item_t beat);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item  <= beat;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		cell_reports_due = {cell_reports_due, apply_to_grid(beat)};
	endtask

	// hold off until every report due has come back
	task automatic wait_for_reports();
		@(negedge clk);
		start <= 1'b0;
		while (cell_reports_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			CFG_ORIGIN_X: grid_ox    = data;
			CFG_ORIGIN_Y: grid_oy    = data;
			CFG_INV_RES:  grid_inv   = data[INV_W-1:0];
			CFG_ROWS:     grid_nrows = data[DIM_W-1:0];
			CFG_COLS:     grid_ncols = data[DIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_grid(input logic signed [COORD_W-1:0] ox, oy,
			input logic [INV_W-1:0] inv, input logic [DIM_W-1:0] nr, nc);
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_INV_RES, {16'd0, inv});
		write_reg(CFG_ROWS, {23'd0, nr});
		write_reg(CFG_COLS, {23'd0, nc});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// reset grid: ten cells per metre, 256 x 256, origin at zero
	task automatic test_default_grid();
		idle_pct = 0;
		send_item(point_beat(0, 0, Q_MAX));
		send_item(point_beat(0, 0, Q_MIN));
		send_item(point_beat(100, 0, 0));
		send_item(point_beat(1671168 + 100, 1677721, 5));
		send_item(point_beat(1677722, 0, 1));
		send_item(point_beat(0, -1, 1));
		send_item(point_beat(Q_MIN, Q_MAX, 1));
		send_item(point_beat(6554, 6554, -7));
		send_item(read_beat(16'd0));
		send_item(read_beat(16'd0));
		send_item(read_beat(16'd65535));
		send_item(read_beat(16'd257));
		wait_for_reports();
	endtask

	// origin and resolution extremes, empty grid, zero resolution, oversize dims
	task automatic test_grid_limits();
		set_grid(Q_MIN, Q_MAX, 16'hFFFF, 9'd3, 9'd5);
		send_item(point_beat(Q_MIN, Q_MAX, 42));
		send_item(point_beat(Q_MAX, Q_MAX, 1));
		send_item(read_beat(16'd14));
		send_item(read_beat(16'd15));
		send_item(read_beat(16'd65535));
		send_item(read_beat(16'd0));
		wait_for_reports();

		set_grid(0, 0, 16'd0, 9'd0, 9'd0);
		send_item(point_beat(0, 0, 3));
		send_item(read_beat(16'd0));
		wait_for_reports();

		// zero resolution folds every point onto the first cell
		set_grid(0, 0, 16'd0, 9'd1, 9'd1);
		send_item(point_beat(Q_MIN, Q_MAX, 3));
		send_item(read_beat(16'd0));
		wait_for_reports();

		set_grid(Q_MAX, 0, 16'd1, 9'd511, 9'd300);
		send_item(point_beat(Q_MAX, Q_MAX, 9));
		send_item(read_beat(16'd65535));
		send_item(read_beat(16'd32512));
		wait_for_reports();
	endtask

	task automatic run_phase(input int pct, input logic signed [COORD_W-1:0] ox, oy,
			input logic [INV_W-1:0] inv, input logic [DIM_W-1:0] nr, nc, input int count);
		set_grid(ox, oy, inv, nr, nc);
		idle_pct = pct;
		repeat (count)
			send_item(traffic_beat());
		wait_for_reports();
	endtask

	// random traffic under several grids and sender idle rates
	task automatic test_random_traffic();
		logic signed [COORD_W-1:0] ox;
		logic signed [COORD_W-1:0] oy;
		ox = COORD_W'($urandom_range(0, 2000000)) - 32'sd1000000;
		oy = COORD_W'($urandom_range(0, 2000000)) - 32'sd1000000;
		run_phase(0, 0, 0, CFG_INV_RES_RST, 9'd8, 9'd8, 115);
		run_phase(62, ox, oy, 16'hFFFF, 9'd16, 9'd4, 115);
		run_phase(27, oy, ox, 16'd1, 9'd1, 9'd1, 115);
		run_phase(0, Q_MIN, Q_MIN, INV_W'($urandom_range(1, 65535)), 9'd256, 9'd256, 115);
		run_phase(62, ox, ox, INV_W'($urandom_range(1, 4000)), 9'd511, 9'd257, 115);
		run_phase(27, oy, oy, CFG_INV_RES_RST, 9'd5, 9'd200, 115);
	endtask

	// result beat check against the oldest report due
	always @(posedge clk) begin : check_beat
		egm_result_t want;
		if (arst_n && done) begin
			if (cell_reports_due.size() == 0) begin
				report_errors++;
				if (report_errors <= REPORT_LIMIT)
					$display("result beat with no report due: status %0d index %0d",
						result.status, result.cell_index);
			end else begin
				want = cell_reports_due.pop_front();
				if (result.status !== want.status || result.cell_index !== want.cell_index ||
						result.cell_valid !== want.cell_valid ||
						result.min_height !== want.min_height ||
						result.max_height !== want.max_height ||
						result.clearance !== want.clearance) begin
					report_errors++;
					if (report_errors <= REPORT_LIMIT)
						$display({"cell report mismatch (want/got): status %0d/%0d index %0d/%0d",
							" valid %0d/%0d min %h/%h max %h/%h clearance %h/%h"},
							want.status, result.status, want.cell_index, result.cell_index,
							want.cell_valid, result.cell_valid, want.min_height,
							result.min_height, want.max_height, result.max_height,
							want.clearance, result.clearance);
				end
			end
		end
	end

	initial begin
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// memory clear sweep after reset
		@(posedge clk);
		while (busy)
			@(posedge clk);

		test_default_grid();
		test_grid_limits();
		test_random_traffic();

		wait_for_reports();
		repeat (EGM_LATENCY + 4)
			@(posedge clk);
		if (report_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[elevation_grid_min_max.f]
+incdir+hdl
hdl/egm_pkg.sv
hdl/egm_cfg.sv
hdl/egm_addr.sv
hdl/egm_mem.sv
hdl/egm_update.sv
hdl/elevation_grid_min_max.sv
hdl/egm_checker.sv
test/elevation_grid_min_max_tb.sv
